>>> hw/rtl/vrpc_pkg.sv
// Package with widths, constants and register indexes of the vertex transform.
`timescale 1ns / 1ps
package vrpc_pkg;

  // Default of the screen limit that sets the saturation range.
  localparam int MAX_SCREEN_WIDTH = 2048;

  // Perspective constants: unity factor and the compression knee.
  localparam int PerspOne  = 'h4000;
  localparam int PerspKnee = 'h4000 / 16;

  // Quotient bits of the depth compression (the result stays below PerspOne).
  localparam int DivSteps = 14;

  // Widths of the internal values.
  localparam int TrigW  = 18;
  localparam int PointW = 16;
  localparam int RotAW  = 19;  // first rotation results
  localparam int RotBW  = 22;  // second rotation results and depth
  localparam int ScrW   = 24;  // scaled screen offsets
  localparam int FacW   = 23;  // perspective factor
  localparam int RemW   = 23;  // divider remainder and divisor

  localparam int InDataW  = 48;
  localparam int OutDataW = 56;

  typedef enum logic [2:0] {
    CfgCosYaw   = 3'd0,
    CfgSinYaw   = 3'd1,
    CfgCosTilt  = 3'd2,
    CfgSinTilt  = 3'd3,
    CfgScale    = 3'd4,
    CfgPersp    = 3'd5,
    CfgWidth    = 3'd6,
    CfgHeight   = 3'd7
  } cfg_idx_e;

  // Values that travel alongside the depth divider.
  typedef struct packed {
    logic                    do_div;
    logic signed [RotBW-1:0] depth;
    logic signed [ScrW-1:0]  sx;
    logic signed [ScrW-1:0]  sy;
  } div_side_t;

endpackage

>>> hw/rtl/vrpc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps
module vrpc_div #(
  parameter int SideW = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [vrpc_pkg::RemW-1:0]       rem_i,
  input  logic [vrpc_pkg::RemW-1:0]       dvs_i,
  input  logic [SideW-1:0]                side_i,
  output logic                            valid_o,
  output logic [vrpc_pkg::DivSteps-1:0]   quo_o,
  output logic [SideW-1:0]                side_o
);

  localparam int N = vrpc_pkg::DivSteps;
  localparam int R = vrpc_pkg::RemW;

  logic [R-1:0]     rem_q  [N];
  logic [R-1:0]     dvs_q  [N];
  logic [N-1:0]     quo_q  [N];
  logic [SideW-1:0] side_q [N];
  logic [N-1:0]     v_q;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [R-1:0] rem_in, dvs_in;
    logic [N-1:0] quo_in;
    logic [SideW-1:0] side_in;
    logic         v_in;
    logic [R:0]   trial, dvs_ext;

    if (k == 0) begin : g_first
      assign rem_in  = rem_i;
      assign dvs_in  = dvs_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign dvs_in  = dvs_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = v_q[k-1];
    end

    assign trial   = {rem_in, 1'b0};
    assign dvs_ext = {1'b0, dvs_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (trial >= dvs_ext) begin
          rem_q[k] <= R'(trial - dvs_ext);
          quo_q[k] <= {quo_in[N-2:0], 1'b1};
        end else begin
          rem_q[k] <= trial[R-1:0];
          quo_q[k] <= {quo_in[N-2:0], 1'b0};
        end
        dvs_q[k]  <= dvs_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign quo_o   = quo_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

>>> hw/rtl/vertex_rotate_project_clip.sv
// Top level of the vertex rotate, project and clip pipeline.
//
//  Channel   Direction  Word contents (lowest bits first)
//  s_axis    in         point_x[15:0], point_y[31:16], point_z[47:32]
//  m_axis    out        screen_x[13:0], screen_y[27:14], depth[44:28],
//                       off_left[45], off_right[46], off_top[47],
//                       off_bottom[48], zeros[55:49]
//  cfg       in         cfg_we_i, cfg_addr_i (register index), cfg_wdata_i
//
// One word is accepted every cycle unless the output stalls. A point passes
// 21 register stages before its result word becomes valid. The stages are
// the four rotation stages (products and sums for yaw and for tilt), the
// scaling stage, the 14-stage depth divider, the perspective multiply and
// the clipping stage. Reset clears all valid bits and loads the register
// defaults. When the output word is not taken the whole pipeline holds, so
// s_axis_tready drops only while a finished word waits and no word is lost
// or repeated.
`timescale 1ns / 1ps
module vertex_rotate_project_clip #(
  parameter int MaxScreenWidth = vrpc_pkg::MAX_SCREEN_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_addr_i,
  input  logic [vrpc_pkg::TrigW-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // point_x, point_y, point_z
  input  logic [vrpc_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // screen_x, screen_y, depth, off_left, off_right, off_top, off_bottom
  output logic [vrpc_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int TW = vrpc_pkg::TrigW;
  localparam int PW = vrpc_pkg::PointW;
  localparam int AW = vrpc_pkg::RotAW;
  localparam int BW = vrpc_pkg::RotBW;
  localparam int SW = vrpc_pkg::ScrW;
  localparam int FW = vrpc_pkg::FacW;
  localparam int RW = vrpc_pkg::RemW;
  localparam int CW = 34;  // centered coordinate width
  localparam int SideW = $bits(vrpc_pkg::div_side_t);
  localparam logic signed [CW-1:0] SatLo = -CW'(MaxScreenWidth);
  localparam logic signed [CW-1:0] SatHi = CW'(2 * MaxScreenWidth);

  // Configuration registers.
  logic signed [TW-1:0] cos_yaw_q, sin_yaw_q, cos_tilt_q, sin_tilt_q;
  logic [11:0] scale_q, width_q, height_q;
  logic        persp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_yaw_q  <= TW'(65536);
      sin_yaw_q  <= '0;
      cos_tilt_q <= TW'(65536);
      sin_tilt_q <= '0;
      scale_q    <= 12'd256;
      persp_q    <= 1'b0;
      width_q    <= 12'd640;
      height_q   <= 12'd480;
    end else if (cfg_we_i) begin
      case (vrpc_pkg::cfg_idx_e'(cfg_addr_i))
        vrpc_pkg::CfgCosYaw:  cos_yaw_q  <= cfg_wdata_i;
        vrpc_pkg::CfgSinYaw:  sin_yaw_q  <= cfg_wdata_i;
        vrpc_pkg::CfgCosTilt: cos_tilt_q <= cfg_wdata_i;
        vrpc_pkg::CfgSinTilt: sin_tilt_q <= cfg_wdata_i;
        vrpc_pkg::CfgScale:   scale_q    <= cfg_wdata_i[11:0];
        vrpc_pkg::CfgPersp:   persp_q    <= cfg_wdata_i[0];
        vrpc_pkg::CfgWidth:   width_q    <= cfg_wdata_i[11:0];
        vrpc_pkg::CfgHeight:  height_q   <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the output register is free or drained.
  logic en;
  logic out_v_q;
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  logic [4:0] v_q;  // valid bits of the stages ahead of the divider

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[3:0], s_axis_tvalid};
    end
  end

  // Stage 1: yaw products.
  logic signed [PW-1:0] px, py, pz;
  assign px = s_axis_tdata[15:0];
  assign py = s_axis_tdata[31:16];
  assign pz = s_axis_tdata[47:32];

  logic signed [TW+PW-1:0] p_cx_q, p_sz_q, p_sx_q, p_cz_q;
  logic signed [PW-1:0]    py1_q, py2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_cx_q <= cos_yaw_q * px;
      p_sz_q <= sin_yaw_q * pz;
      p_sx_q <= sin_yaw_q * px;
      p_cz_q <= cos_yaw_q * pz;
      py1_q  <= py;
    end
  end

  // Stage 2: yaw sums, floor shifted by 16.
  logic signed [TW+PW:0] sum_a, sum_b, ea1, ea2, eb1, eb2;
  assign ea1   = p_cx_q;
  assign ea2   = p_sz_q;
  assign eb1   = p_sx_q;
  assign eb2   = p_cz_q;
  assign sum_a = ea1 - ea2;
  assign sum_b = eb1 + eb2;

  logic signed [AW-1:0] ra_q, rb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ra_q  <= sum_a[TW+PW:16];
      rb_q  <= sum_b[TW+PW:16];
      py2_q <= py1_q;
    end
  end

  // Stage 3: tilt products and the x scaling.
  logic signed [TW+PW-1:0] t_cy_q, t_sy_q;
  logic signed [TW+AW-1:0] t_sb_q, t_cb_q;
  logic signed [13+AW-1:0] sc_x_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_cy_q <= cos_tilt_q * py2_q;
      t_sy_q <= sin_tilt_q * py2_q;
      t_sb_q <= sin_tilt_q * rb_q;
      t_cb_q <= cos_tilt_q * rb_q;
      sc_x_q <= $signed({1'b0, scale_q}) * ra_q;
    end
  end

  // Stage 4: tilt sums give the row value and the depth.
  logic signed [TW+AW:0] sum_c, sum_d, ec1, ec2, ed1, ed2;
  assign ec1   = t_cy_q;
  assign ec2   = t_sb_q;
  assign ed1   = t_sy_q;
  assign ed2   = t_cb_q;
  assign sum_c = ec1 - ec2;
  assign sum_d = ed1 + ed2;

  logic signed [BW-1:0] rc_q, d4_q;
  logic signed [SW-1:0] sx4_q;
  logic signed [13+AW-12:0] sx_sh;
  assign sx_sh = sc_x_q[13+AW-1:11];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rc_q  <= sum_c[TW+AW:16];
      d4_q  <= sum_d[TW+AW:16];
      sx4_q <= SW'(sx_sh);
    end
  end

  // Stage 5: y scaling and divider set-up.
  logic signed [13+BW-1:0] sc_y;
  assign sc_y = $signed({1'b0, scale_q}) * rc_q;

  vrpc_pkg::div_side_t side5_q, side_out;
  logic [RW-1:0] rem5_q, dvs5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side5_q.do_div <= persp_q && (d4_q > BW'(vrpc_pkg::PerspKnee));
      side5_q.depth  <= d4_q;
      side5_q.sx     <= sx4_q;
      side5_q.sy     <= sc_y[13+BW-1:11];
      rem5_q         <= RW'(d4_q);
      dvs5_q         <= RW'(d4_q) + RW'(vrpc_pkg::PerspOne);
    end
  end

  // Stages 6 to 19: depth compression, one quotient bit per stage.
  logic                          div_v;
  logic [vrpc_pkg::DivSteps-1:0] quo;

  vrpc_div #(
    .SideW (SideW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[4]),
    .rem_i   (rem5_q),
    .dvs_i   (dvs5_q),
    .side_i  (side5_q),
    .valid_o (div_v),
    .quo_o   (quo),
    .side_o  (side_out)
  );

  // Stage 20: final depth and the perspective multiply.
  logic signed [BW-1:0] dfin;
  logic signed [FW-1:0] factor;
  assign dfin   = side_out.do_div ? BW'(quo) : side_out.depth;
  assign factor = FW'(vrpc_pkg::PerspOne) - FW'(dfin);

  logic                    m_v_q;
  logic signed [SW+FW-1:0] mx_q, my_q;
  logic signed [SW-1:0]    sx_m_q, sy_m_q;
  logic signed [BW-1:0]    d_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q   <= side_out.sx * factor;
      my_q   <= side_out.sy * factor;
      sx_m_q <= side_out.sx;
      sy_m_q <= side_out.sy;
      d_m_q  <= dfin;
    end
  end

  // Stage 21: centering, edge flags and saturation into the output word.
  logic signed [CW-1:0] offx, offy, cx, cy, cx_sat, cy_sat;
  logic                 fl, fr, ft, fb;
  logic [16:0]          dq;

  always_comb begin
    if (persp_q) begin
      offx = CW'($signed(mx_q[SW+FW-1:14]));
      offy = CW'($signed(my_q[SW+FW-1:14]));
    end else begin
      offx = CW'(sx_m_q);
      offy = CW'(sy_m_q);
    end
    cx = $signed({{(CW-11){1'b0}}, width_q[11:1]}) + offx;
    cy = $signed({{(CW-11){1'b0}}, height_q[11:1]}) - offy;

    fl = 1'b0;
    fr = 1'b0;
    cx_sat = cx;
    if (cx < 0) begin
      fl = 1'b1;
      if (cx < SatLo) cx_sat = SatLo;
    end else if (cx >= $signed({{(CW-12){1'b0}}, width_q})) begin
      fr = 1'b1;
      if (cx > SatHi) cx_sat = SatHi;
    end

    ft = 1'b0;
    fb = 1'b0;
    cy_sat = cy;
    if (cy < 0) begin
      ft = 1'b1;
      if (cy < SatLo) cy_sat = SatLo;
    end else if (cy >= $signed({{(CW-12){1'b0}}, height_q})) begin
      fb = 1'b1;
      if (cy > SatHi) cy_sat = SatHi;
    end

    // Depth field saturates to the 17-bit signed range.
    if (d_m_q < -BW'(65536)) begin
      dq = 17'h10000;
    end else if (d_m_q > BW'(65535)) begin
      dq = 17'h0FFFF;
    end else begin
      dq = d_m_q[16:0];
    end
  end

  logic [vrpc_pkg::OutDataW-1:0] out_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_d_q <= {7'd0, fb, ft, fr, fl, dq, cy_sat[13:0], cx_sat[13:0]};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_d_q;

endmodule

>>> hw/rtl/vrpc_checker.sv
// Port-level checker for the vertex transform, bound to the top level.
`timescale 1ns / 1ps
module vrpc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [vrpc_pkg::OutDataW-1:0] m_axis_tdata
);

  // A column cannot be off both edges at once; likewise a row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[45] && m_axis_tdata[46]) &&
                      !(m_axis_tdata[47] && m_axis_tdata[48]))
    else $error("both horizontal or both vertical edge flags set");

  // Off the left or top edge means a negative coordinate.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[45] |-> m_axis_tdata[13])
    else $error("off_left with a non-negative column");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[47] |-> m_axis_tdata[27])
    else $error("off_top with a non-negative row");

  // A waiting result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  // Input is refused only while an output word waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

endmodule

bind vertex_rotate_project_clip vrpc_checker u_vrpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> dv/vertex_rotate_project_clip_tb.sv
// Testbench of the vertex rotate, project and clip pipeline.
`timescale 1ns / 1ps
module vertex_rotate_project_clip_tb;

  // Result of one projected point, as the output word carries it.
  typedef struct packed {
    logic       off_bottom;
    logic       off_top;
    logic       off_right;
    logic       off_left;
    logic [16:0] depth;
    logic [13:0] screen_y;
    logic [13:0] screen_x;
  } proj_t;

  localparam int  Latency  = 21;
  localparam longint Limit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_addr_i = '0;
  logic [vrpc_pkg::TrigW-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // point_x, point_y, point_z
  logic [vrpc_pkg::InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // screen_x, screen_y, depth, off_left, off_right, off_top, off_bottom
  logic [vrpc_pkg::OutDataW-1:0] m_axis_tdata;

  vertex_rotate_project_clip u_top (.*);

  always #6 clk_i = ~clk_i;

  // Shadow copy of the camera registers.
  longint cam_cos_yaw, cam_sin_yaw, cam_cos_tilt, cam_sin_tilt;
  longint cam_scale, cam_persp, cam_width, cam_height;

  proj_t  expected_points[$];
  int     mismatches;
  bit     timed_out;
  bit     no_idle;       // while set, neither side idles
  int     hold_cycles;   // receiver hold-off requested by a test
  longint cycle_count;

  // Floor shift of a wide signed value.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic proj_t project_point(logic [15:0] px_in, logic [15:0] py_in,
                                          logic [15:0] pz_in);
    longint px, py, pz, ra, rb, rc, d, sx, sy, cx, cy, dq;
    proj_t r;
    px = longint'($signed(px_in));
    py = longint'($signed(py_in));
    pz = longint'($signed(pz_in));
    r = '0;
    ra = floor_shift(cam_cos_yaw * px - cam_sin_yaw * pz, 16);
    rb = floor_shift(cam_sin_yaw * px + cam_cos_yaw * pz, 16);
    rc = floor_shift(cam_cos_tilt * py - cam_sin_tilt * rb, 16);
    d  = floor_shift(cam_sin_tilt * py + cam_cos_tilt * rb, 16);
    if (cam_persp != 0 && d > vrpc_pkg::PerspKnee)
      d = (vrpc_pkg::PerspOne * d) / (d + vrpc_pkg::PerspOne);
    sx = floor_shift(cam_scale * ra, 11);
    sy = floor_shift(cam_scale * rc, 11);
    if (cam_persp != 0) begin
      sx = floor_shift(sx * (vrpc_pkg::PerspOne - d), 14);
      sy = floor_shift(sy * (vrpc_pkg::PerspOne - d), 14);
    end
    cx = cam_width / 2 + sx;
    if (cx < 0) begin
      if (cx < -vrpc_pkg::MAX_SCREEN_WIDTH) cx = -vrpc_pkg::MAX_SCREEN_WIDTH;
      r.off_left = 1'b1;
    end else if (cx >= cam_width) begin
      if (cx > 2 * vrpc_pkg::MAX_SCREEN_WIDTH) cx = 2 * vrpc_pkg::MAX_SCREEN_WIDTH;
      r.off_right = 1'b1;
    end
    cy = cam_height / 2 - sy;
    if (cy < 0) begin
      if (cy < -vrpc_pkg::MAX_SCREEN_WIDTH) cy = -vrpc_pkg::MAX_SCREEN_WIDTH;
      r.off_top = 1'b1;
    end else if (cy >= cam_height) begin
      if (cy > 2 * vrpc_pkg::MAX_SCREEN_WIDTH) cy = 2 * vrpc_pkg::MAX_SCREEN_WIDTH;
      r.off_bottom = 1'b1;
    end
    dq = d;
    if (dq < -65536) dq = -65536;
    if (dq > 65535) dq = 65535;
    r.screen_x = cx[13:0];
    r.screen_y = cy[13:0];
    r.depth = dq[16:0];
    return r;
  endfunction

  // Writes one camera register; the caller drops the write enable afterwards.
  task automatic write_reg(vrpc_pkg::cfg_idx_e idx, logic [vrpc_pkg::TrigW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      vrpc_pkg::CfgCosYaw:  cam_cos_yaw  = longint'($signed(value));
      vrpc_pkg::CfgSinYaw:  cam_sin_yaw  = longint'($signed(value));
      vrpc_pkg::CfgCosTilt: cam_cos_tilt = longint'($signed(value));
      vrpc_pkg::CfgSinTilt: cam_sin_tilt = longint'($signed(value));
      vrpc_pkg::CfgScale:   cam_scale    = longint'(value[11:0]);
      vrpc_pkg::CfgPersp:   cam_persp    = longint'(value[0]);
      vrpc_pkg::CfgWidth:   cam_width    = longint'(value[11:0]);
      vrpc_pkg::CfgHeight:  cam_height   = longint'(value[11:0]);
      default: ;
    endcase
  endtask

  // Loads all camera registers; only called while the pipeline is empty.
  task automatic set_camera(int cy, int sy, int ct, int st, int scale, int persp,
                            int w, int h);
    write_reg(vrpc_pkg::CfgCosYaw, cy[vrpc_pkg::TrigW-1:0]);
    write_reg(vrpc_pkg::CfgSinYaw, sy[vrpc_pkg::TrigW-1:0]);
    write_reg(vrpc_pkg::CfgCosTilt, ct[vrpc_pkg::TrigW-1:0]);
    write_reg(vrpc_pkg::CfgSinTilt, st[vrpc_pkg::TrigW-1:0]);
    write_reg(vrpc_pkg::CfgScale, scale[vrpc_pkg::TrigW-1:0]);
    write_reg(vrpc_pkg::CfgPersp, persp[vrpc_pkg::TrigW-1:0]);
    write_reg(vrpc_pkg::CfgWidth, w[vrpc_pkg::TrigW-1:0]);
    write_reg(vrpc_pkg::CfgHeight, h[vrpc_pkg::TrigW-1:0]);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one point word, sometimes after a random gap, and waits for acceptance.
  // The valid stays high afterwards so that points can follow back to back.
  task automatic send_point(logic [15:0] px, logic [15:0] py, logic [15:0] pz);
    if (!no_idle && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 27);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pz, py, px};
    expected_points.push_back(project_point(px, py, pz));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Lets the pipeline run empty before a register write.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // Random coordinate, biased toward small and extreme values.
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($signed($urandom_range(4000)) - 2000);
      2: return $urandom_range(1) ? 16'h7fff - 16'($urandom_range(3)) : 16'h8000
                                  + 16'($urandom_range(3));
      default: return 16'($signed($urandom_range(600)) - 300);
    endcase
  endfunction

  function automatic int rand_trig();
    case ($urandom_range(4))
      0: return 65536;
      1: return -65536;
      2: return 0;
      default: return $signed($urandom_range(131072)) - 65536;
    endcase
  endfunction

  // Receiver: stalls at random, or for a long stretch when asked.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 27);
    end
  end

  // Checks each accepted result against the oldest projected point.
  always @(posedge clk_i) begin
    proj_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = proj_t'(m_axis_tdata[48:0]);
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata);
      end else begin
        want = expected_points.pop_front();
        if (got !== want || m_axis_tdata[55:49] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%0d y=%0d d=%0d fl=%b got x=%0d y=%0d d=%0d fl=%b",
                     $signed(want.screen_x), $signed(want.screen_y),
                     $signed(want.depth),
                     {want.off_left, want.off_right, want.off_top, want.off_bottom},
                     $signed(got.screen_x), $signed(got.screen_y), $signed(got.depth),
                     {got.off_left, got.off_right, got.off_top, got.off_bottom});
        end
      end
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > Limit && !timed_out) begin
      timed_out = 1'b1;
      $display("vertex_rotate_project_clip_tb: FAIL");
      $finish;
    end
  end

  // Reset defaults, then extreme coordinates and every special case.
  task automatic test_directed;
    int i;
    logic [15:0] pick [6] = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'h0001, 16'h0400};
    // Reset values: identity rotation, no perspective.
    for (i = 0; i < 6; i++) send_point(pick[i], pick[(i + 2) % 6], pick[(i + 4) % 6]);
    drain();
    // Perspective with depth below, at and above the knee, and negative.
    set_camera(65536, 0, 65536, 0, 4095, 1, 2048, 2048);
    send_point(16'd100, 16'd50, 16'd1024);
    send_point(16'd100, 16'd50, 16'd1025);
    send_point(16'h8000, 16'h7fff, 16'h7fff);
    send_point(16'h7fff, 16'h8000, 16'h8000);
    send_point(16'd0, 16'd0, 16'd20000);
    // Point inside the window, unchanged.
    send_point(16'd2, 16'd3, 16'd0);
    drain();
    // Extreme rotations, zero and tiny windows.
    set_camera(-65536, 65536, -65536, -65536, 0, 0, 0, 0);
    send_point(16'h7fff, 16'h7fff, 16'h8000);
    send_point(16'd0, 16'd0, 16'd0);
    drain();
    set_camera(0, -65536, 0, 65536, 1, 1, 1, 1);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h0001, 16'hffff, 16'h0001);
    drain();
    // Largest positive register values, beyond the stated range.
    set_camera(131071, 131071, 131071, 131071, 4095, 1, 4095, 4095);
    send_point(16'h7fff, 16'h8000, 16'h7fff);
    send_point(16'h1234, 16'hedcb, 16'h8000);
    drain();
  endtask

  // Random points under a series of random camera settings.
  task automatic test_random(int settings, int points);
    int s, n;
    for (s = 0; s < settings; s++) begin
      set_camera(rand_trig(), rand_trig(), rand_trig(), rand_trig(),
                 $urandom_range(1) ? $urandom_range(4095) : $urandom_range(400),
                 $urandom_range(1), $urandom_range(1, 2048), $urandom_range(1, 2048));
      no_idle = (s == 3);
      for (n = 0; n < points; n++) send_point(rand_coord(), rand_coord(), rand_coord());
      drain();
    end
    no_idle = 1'b0;
  endtask

  // Long receiver hold-off while points keep arriving, so the input stalls.
  task automatic test_backpressure;
    int n;
    hold_cycles = 120;
    for (n = 0; n < 80; n++) send_point(rand_coord(), rand_coord(), rand_coord());
    drain();
  endtask

  initial begin
    mismatches = 0;
    timed_out = 1'b0;
    no_idle = 1'b0;
    hold_cycles = 0;
    cycle_count = 0;
    cam_cos_yaw = 65536; cam_sin_yaw = 0; cam_cos_tilt = 65536; cam_sin_tilt = 0;
    cam_scale = 256; cam_persp = 0; cam_width = 640; cam_height = 480;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(30, 60);
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("vertex_rotate_project_clip_tb: PASS");
    end else begin
      $display("vertex_rotate_project_clip_tb: FAIL");
    end
    $finish;
  end
endmodule
